// ===== sv/session_timeout_table_assert.svh =====
// Assertion macros for the session timeout table.
// Included by the top level; no other dependencies.
`ifndef SESSION_TIMEOUT_TABLE_ASSERT_SVH
`define SESSION_TIMEOUT_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define STT_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define STT_ASSERT_NXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`else

`define STT_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg)
`define STT_ASSERT_NXT(label, clk, rst_n, lhs, rhs, msg)

`endif

`endif

// ===== sv/stt_pkg.sv =====
// Shared types and constants for the session timeout table.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package stt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic [15:0] DEFAULT_TIMEOUT = 16'd30;

    typedef enum logic [1:0] {
        CMD_REGISTER   = 2'd0,
        CMD_UNREGISTER = 2'd1,
        CMD_REFRESH    = 2'd2,
        CMD_SWEEP      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // One stored session
    typedef struct packed {
        logic [31:0] user_id;
        logic [15:0] tag;
        logic [31:0] last_seen;
    } entry_t;

    // One result item
    typedef struct packed {
        status_t     status;
        logic        start_timer;
        logic        expired_valid;
        logic [31:0] expired_user_id;
        logic [15:0] expired_tag;
        logic        table_not_empty;
        logic        last;
    } result_t;

endpackage

// ===== sv/stt_in_if.sv =====
// Request channel of the session timeout table: valid/ready plus command fields.
// Depends on stt_pkg.
`timescale 1ns / 1ps

interface stt_in_if
    import stt_pkg::*;
;
    logic               valid;
    logic               ready;
    logic        [1:0]  command;
    logic signed [31:0] user_id;
    logic        [15:0] session_tag;
    logic        [31:0] current_time;

    modport source (
        output valid, command, user_id, session_tag, current_time,
        input  ready
    );

    modport sink (
        input  valid, command, user_id, session_tag, current_time,
        output ready
    );
endinterface

// ===== sv/stt_out_if.sv =====
// Result channel of the session timeout table: valid/ready plus result fields.
// Depends on stt_pkg.
`timescale 1ns / 1ps

interface stt_out_if
    import stt_pkg::*;
;
    logic               valid;
    logic               ready;
    logic        [1:0]  status;
    logic               start_timer;
    logic               expired_valid;
    logic signed [31:0] expired_user_id;
    logic        [15:0] expired_tag;
    logic               table_not_empty;
    logic               last;

    modport source (
        output valid, status, start_timer, expired_valid, expired_user_id,
               expired_tag, table_not_empty, last,
        input  ready
    );

    modport sink (
        input  valid, status, start_timer, expired_valid, expired_user_id,
               expired_tag, table_not_empty, last,
        output ready
    );
endinterface

// ===== sv/session_timeout_table.sv =====
// Session timeout table: sorted table of sessions in a two-port RAM, walked by a sequencer.
// One request at a time: the next is taken once the last result loads into the output register;
// output stalls hold the sequencer in its emit state. Each table step is a read state, then a
// compare or write state (registered read).
// Reset (async, rst_n low): entry count zero, timeout 30 s, output empty; no RAM clear.
// Depends on stt_pkg, stt_in_if, stt_out_if and session_timeout_table_assert.svh.
`timescale 1ns / 1ps
`include "session_timeout_table_assert.svh"

module session_timeout_table
    import stt_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_write_en,
    input  logic [15:0]     cfg_write_data,
    stt_in_if.sink          req,
    stt_out_if.source       rsp
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CMP,
        S_DECIDE,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_SW_RD,
        S_SW_EVAL,
        S_EMIT
    } state_t;

    // Control registers
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   wr_reg, wr_next;
    logic               hit_reg, hit_next;
    logic [15:0]        timeout_reg, timeout_next;
    logic               out_valid_reg, out_valid_next;

    // Payload registers
    cmd_t               cmd_reg, cmd_next;
    logic [31:0]        uid_reg, uid_next;
    logic [15:0]        tag_reg, tag_next;
    logic [31:0]        now_reg, now_next;
    result_t            res_reg, res_next;
    result_t            out_reg, out_next;

    // Table RAM
    entry_t             mem [TABLE_DEPTH];
    entry_t             rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    entry_t             mem_wdata;

    // Datapath helpers
    logic [CNT_W-1:0]   idx_dec;
    logic [CNT_W-1:0]   idx_inc;
    logic [47:0]        ent_key;
    logic [47:0]        req_key;
    logic [31:0]        idle_time;
    logic               expired;
    logic               out_free;

    function automatic result_t make_result(status_t st, logic start, logic ev,
                                            logic [31:0] euid, logic [15:0] etag,
                                            logic nonempty, logic fin);
        result_t r;
        r.status          = st;
        r.start_timer     = start;
        r.expired_valid   = ev;
        r.expired_user_id = euid;
        r.expired_tag     = etag;
        r.table_not_empty = nonempty;
        r.last            = fin;
        return r;
    endfunction

    // Key order: user id as signed (sign bit flipped), then tag unsigned
    assign ent_key = {~rd_data_reg.user_id[31], rd_data_reg.user_id[30:0], rd_data_reg.tag};
    assign req_key = {~uid_reg[31], uid_reg[30:0], tag_reg};

    // Idle time check; negative difference never times out
    assign idle_time = now_reg - rd_data_reg.last_seen;
    assign expired   = !idle_time[31] && (idle_time > {16'd0, timeout_reg});

    assign idx_dec  = idx_reg - CNT_W'(1);
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign out_free = !out_valid_reg || rsp.ready;

    // Handshake and output drive
    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_reg.status;
    assign rsp.start_timer     = out_reg.start_timer;
    assign rsp.expired_valid   = out_reg.expired_valid;
    assign rsp.expired_user_id = out_reg.expired_user_id;
    assign rsp.expired_tag     = out_reg.expired_tag;
    assign rsp.table_not_empty = out_reg.table_not_empty;
    assign rsp.last            = out_reg.last;

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        wr_next        = wr_reg;
        hit_next       = hit_reg;
        timeout_next   = timeout_reg;
        cmd_next       = cmd_reg;
        uid_next       = uid_reg;
        tag_next       = tag_reg;
        now_next       = now_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        rd_addr        = idx_reg[ADDR_W-1:0];
        mem_we         = 1'b0;
        mem_waddr      = idx_reg[ADDR_W-1:0];
        mem_wdata      = rd_data_reg;

        if (cfg_write_en)
        begin
            timeout_next = cfg_write_data;
        end

        // Result taken downstream
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = cmd_t'(req.command);
                    uid_next   = req.user_id;
                    tag_next   = req.session_tag;
                    now_next   = req.current_time;
                    idx_next   = '0;
                    wr_next    = '0;
                    hit_next   = 1'b0;
                    state_next = (cmd_t'(req.command) == CMD_SWEEP) ? S_SW_RD : S_FIND_RD;
                end
            end

            // Linear search for the first key not below the request key
            S_FIND_RD:
            begin
                if (idx_reg >= count_reg)
                begin
                    pos_next   = idx_reg;
                    hit_next   = 1'b0;
                    state_next = S_DECIDE;
                end
                else
                begin
                    state_next = S_FIND_CMP;
                end
            end

            S_FIND_CMP:
            begin
                if (ent_key == req_key)
                begin
                    pos_next   = idx_reg;
                    hit_next   = 1'b1;
                    state_next = S_DECIDE;
                end
                else if (ent_key > req_key)
                begin
                    pos_next   = idx_reg;
                    hit_next   = 1'b0;
                    state_next = S_DECIDE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_FIND_RD;
                end
            end

            S_DECIDE:
            begin
                state_next = S_EMIT;
                case (cmd_reg)
                    CMD_REGISTER:
                    begin
                        if (hit_reg)
                        begin
                            res_next = make_result(ST_DUPLICATE, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
                        end
                        else if (count_reg >= CNT_W'(TABLE_DEPTH))
                        begin
                            res_next = make_result(ST_FULL, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
                        end
                        else
                        begin
                            idx_next   = count_reg;
                            state_next = S_INS_RD;
                        end
                    end
                    CMD_UNREGISTER:
                    begin
                        if (!hit_reg)
                        begin
                            res_next = make_result(ST_NOT_FOUND, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
                        end
                        else
                        begin
                            idx_next   = pos_reg;
                            state_next = S_DEL_RD;
                        end
                    end
                    CMD_REFRESH:
                    begin
                        if (!hit_reg)
                        begin
                            res_next = make_result(ST_NOT_FOUND, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = pos_reg[ADDR_W-1:0];
                            mem_wdata = '{user_id: uid_reg, tag: tag_reg, last_seen: now_reg};
                            res_next  = make_result(ST_OK, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
                        end
                    end
                    default:
                    begin
                        res_next = make_result(ST_OK, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
                    end
                endcase
            end

            // Insert: move entries up one slot from the top down to the position
            S_INS_RD:
            begin
                if (idx_reg == pos_reg)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = pos_reg[ADDR_W-1:0];
                    mem_wdata  = '{user_id: uid_reg, tag: tag_reg, last_seen: now_reg};
                    count_next = count_reg + CNT_W'(1);
                    res_next   = make_result(ST_OK, (count_reg == '0), 1'b0, '0, '0, 1'b0,
                                             1'b1);
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_addr    = idx_dec[ADDR_W-1:0];
                    state_next = S_INS_WR;
                end
            end

            S_INS_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[ADDR_W-1:0];
                mem_wdata  = rd_data_reg;
                idx_next   = idx_dec;
                state_next = S_INS_RD;
            end

            // Delete: move entries above the position down one slot
            S_DEL_RD:
            begin
                if (idx_inc >= count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    res_next   = make_result(ST_OK, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_addr    = idx_inc[ADDR_W-1:0];
                    state_next = S_DEL_WR;
                end
            end

            S_DEL_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[ADDR_W-1:0];
                mem_wdata  = rd_data_reg;
                idx_next   = idx_inc;
                state_next = S_DEL_RD;
            end

            // Sweep: compact survivors, report expired entries in order
            S_SW_RD:
            begin
                if (idx_reg >= count_reg)
                begin
                    count_next = wr_reg;
                    res_next   = make_result(ST_OK, 1'b0, 1'b0, '0, '0, (wr_reg != '0), 1'b1);
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_SW_EVAL;
                end
            end

            S_SW_EVAL:
            begin
                idx_next = idx_inc;
                if (expired)
                begin
                    res_next   = make_result(ST_OK, 1'b0, 1'b1, rd_data_reg.user_id,
                                             rd_data_reg.tag, 1'b0, 1'b0);
                    state_next = S_EMIT;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = wr_reg[ADDR_W-1:0];
                    mem_wdata  = rd_data_reg;
                    wr_next    = wr_reg + CNT_W'(1);
                    state_next = S_SW_RD;
                end
            end

            // Hand the pending result to the output register
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = res_reg.last ? S_IDLE : S_SW_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            wr_reg        <= '0;
            hit_reg       <= 1'b0;
            timeout_reg   <= DEFAULT_TIMEOUT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            wr_reg        <= wr_next;
            hit_reg       <= hit_next;
            timeout_reg   <= timeout_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        uid_reg <= uid_next;
        tag_reg <= tag_next;
        now_reg <= now_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    // Table RAM: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Checks
    `STT_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, (count_reg <= CNT_W'(TABLE_DEPTH)),
        "entry count beyond table depth")
    `STT_ASSERT_IMP(a_mid_is_expired, clk, rst_n, (rsp.valid && !rsp.last),
        (rsp.expired_valid && rsp.status == ST_OK), "non-final result without an expiry")
    `STT_ASSERT_IMP(a_start_ok, clk, rst_n, (rsp.valid && rsp.start_timer),
        (rsp.status == ST_OK && rsp.last && !rsp.expired_valid), "timer start on bad result")
    `STT_ASSERT_NXT(a_busy_after_req, clk, rst_n, (req.valid && req.ready),
        (state_reg != S_IDLE), "sequencer idle right after a request")

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for session_timeout_table: directed and random session requests.
// Scoreboard class predicts the sorted session table; depends on stt_pkg, stt_in_if, stt_out_if.
`timescale 1ns / 1ps

module tb_top
    import stt_pkg::*;
;

    // Session table predictor and result checker
    class session_scoreboard;
        entry_t      slots[TABLE_DEPTH];
        int          entry_cnt;
        logic [15:0] timeout_s;
        result_t     expected_results[$];
        int          errors;
        int          accepted;

        function new();
            entry_cnt = 0;
            timeout_s = DEFAULT_TIMEOUT;
            errors    = 0;
            accepted  = 0;
        endfunction

        function void queue_result(status_t st, logic start, logic ev, logic [31:0] uid,
                                   logic [15:0] tag, logic nonempty, logic lst);
            result_t r;
            r.status          = st;
            r.start_timer     = start;
            r.expired_valid   = ev;
            r.expired_user_id = uid;
            r.expired_tag     = tag;
            r.table_not_empty = nonempty;
            r.last            = lst;
            expected_results.push_back(r);
        endfunction

        // Key order: user id signed, then tag unsigned
        function bit key_below(entry_t e, logic [31:0] uid, logic [15:0] tag);
            if ($signed(e.user_id) < $signed(uid))
                return 1'b1;
            return (e.user_id == uid) && (e.tag < tag);
        endfunction

        // Update the table for one accepted request and queue its results
        function void apply_command(cmd_t cmd, logic [31:0] uid, logic [15:0] tag,
                                    logic [31:0] now);
            int          pos;
            int          w;
            bit          hit;
            logic [31:0] d;
            accepted++;
            if (cmd == CMD_SWEEP)
            begin
                w = 0;
                for (int i = 0; i < entry_cnt; i++)
                begin
                    d = now - slots[i].last_seen;
                    // negative difference (clock went back) never expires
                    if (!d[31] && (d > {16'd0, timeout_s}))
                        queue_result(ST_OK, 1'b0, 1'b1, slots[i].user_id, slots[i].tag,
                                     1'b0, 1'b0);
                    else
                    begin
                        slots[w] = slots[i];
                        w++;
                    end
                end
                entry_cnt = w;
                queue_result(ST_OK, 1'b0, 1'b0, '0, '0, entry_cnt != 0, 1'b1);
                return;
            end

            pos = 0;
            while (pos < entry_cnt && key_below(slots[pos], uid, tag))
                pos++;
            hit = 1'b0;
            if (pos < entry_cnt)
                hit = (slots[pos].user_id == uid) && (slots[pos].tag == tag);

            case (cmd)
                CMD_REGISTER:
                begin
                    // duplicate wins over full
                    if (hit)
                        queue_result(ST_DUPLICATE, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
                    else if (entry_cnt >= TABLE_DEPTH)
                        queue_result(ST_FULL, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
                    else
                    begin
                        for (int i = entry_cnt; i > pos; i--)
                            slots[i] = slots[i - 1];
                        slots[pos].user_id   = uid;
                        slots[pos].tag       = tag;
                        slots[pos].last_seen = now;
                        queue_result(ST_OK, entry_cnt == 0, 1'b0, '0, '0, 1'b0, 1'b1);
                        entry_cnt++;
                    end
                end
                CMD_UNREGISTER:
                begin
                    if (!hit)
                        queue_result(ST_NOT_FOUND, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
                    else
                    begin
                        for (int i = pos; i + 1 < entry_cnt; i++)
                            slots[i] = slots[i + 1];
                        entry_cnt--;
                        queue_result(ST_OK, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
                    end
                end
                default:
                begin
                    if (!hit)
                        queue_result(ST_NOT_FOUND, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
                    else
                    begin
                        slots[pos].last_seen = now;
                        queue_result(ST_OK, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, e, a);
            end
        endfunction

        // Compare one result against the oldest expectation
        function void check_result(result_t got);
            result_t exp_r;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with no request outstanding: expected none, got %0h",
                         $time, got);
                return;
            end
            exp_r = expected_results.pop_front();
            compare_field("status", 32'(exp_r.status), 32'(got.status));
            compare_field("start_timer", 32'(exp_r.start_timer), 32'(got.start_timer));
            compare_field("expired_valid", 32'(exp_r.expired_valid), 32'(got.expired_valid));
            compare_field("expired_user_id", exp_r.expired_user_id, got.expired_user_id);
            compare_field("expired_tag", 32'(exp_r.expired_tag), 32'(got.expired_tag));
            compare_field("table_not_empty", 32'(exp_r.table_not_empty),
                          32'(got.table_not_empty));
            compare_field("last", 32'(exp_r.last), 32'(got.last));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [15:0] cfg_write_data;

    stt_in_if  req_ch ();
    stt_out_if rsp_ch ();

    session_scoreboard sb = new();

    bit          no_idle;
    logic [31:0] now_s;
    logic [31:0] uid_pool[8];
    logic [15:0] tag_pool[4];

    session_timeout_table dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .req            (req_ch),
        .rsp            (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int idle_cycles();
        if (no_idle)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    // Offer one request and wait until it is taken
    task automatic drive_request(input cmd_t cmd, input logic [31:0] uid,
                                 input logic [15:0] tag, input logic [31:0] when);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.command      <= cmd;
        req_ch.user_id      <= uid;
        req_ch.session_tag  <= tag;
        req_ch.current_time <= when;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.apply_command(cmd, uid, tag, when);
    endtask

    // Drain all outstanding results before touching the register
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic set_timeout(input logic [15:0] value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        sb.timeout_s = value;
    endtask

    // Ordering, boundaries, missing keys, backward and wrapping clock
    task automatic directed_checks();
        logic [31:0] t0;
        t0 = 32'h0000_1000;
        drive_request(CMD_SWEEP, 32'd0, 16'd0, t0);
        drive_request(CMD_UNREGISTER, 32'd5, 16'd7, t0);
        drive_request(CMD_REFRESH, 32'd5, 16'd7, t0);
        drive_request(CMD_REGISTER, 32'd0, 16'd0, t0);
        drive_request(CMD_REGISTER, 32'd0, 16'd0, t0);
        drive_request(CMD_REGISTER, 32'h8000_0000, 16'd0, t0);
        drive_request(CMD_REGISTER, 32'h7FFF_FFFF, 16'hFFFF, t0);
        drive_request(CMD_REGISTER, 32'd0, 16'hFFFF, t0 + 5);
        drive_request(CMD_REGISTER, 32'hFFFF_FFFF, 16'h8000, t0);
        drive_request(CMD_REFRESH, 32'd0, 16'd0, t0 + 10);
        // idle exactly at the timeout stays, one more second expires
        drive_request(CMD_SWEEP, 32'hFFFF_FFFF, 16'hFFFF, t0 + 30);
        drive_request(CMD_SWEEP, 32'd0, 16'd0, t0 + 31);
        drive_request(CMD_SWEEP, 32'd0, 16'd0, t0 - 100);
        drive_request(CMD_UNREGISTER, 32'd0, 16'd0, t0);
        drive_request(CMD_UNREGISTER, 32'd0, 16'd0, t0);
        // time wraps past 2^32
        drive_request(CMD_REFRESH, 32'd0, 16'hFFFF, 32'hFFFF_FFF0);
        drive_request(CMD_SWEEP, 32'd0, 16'd0, 32'h0000_0005);
        drive_request(CMD_SWEEP, 32'd0, 16'd0, 32'h0000_0010);
        drive_request(CMD_REGISTER, 32'h5A5A_A5A5, 16'hA5A5, 32'hFFFF_FFFF);
        drive_request(CMD_REFRESH, 32'h5A5A_A5A5, 16'hA5A5, 32'd0);
        drive_request(CMD_UNREGISTER, 32'h5A5A_A5A5, 16'hA5A5, 32'd0);
    endtask

    // Mostly session traffic on a small key pool, some noise
    task automatic random_phase(input int n, input int max_step);
        int          r;
        int          j;
        cmd_t        cmd;
        logic [31:0] uid;
        logic [15:0] tag;
        logic [31:0] when;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0)
                now_s = now_s - $urandom_range(1, max_step + 1);
            else
                now_s = now_s + $urandom_range(0, max_step);
            uid  = uid_pool[$urandom_range(0, 7)];
            tag  = tag_pool[$urandom_range(0, 3)];
            when = now_s;
            if (r < 35)
                cmd = CMD_REGISTER;
            else if (r < 75)
            begin
                cmd = (r < 60) ? CMD_REFRESH : CMD_UNREGISTER;
                if (sb.entry_cnt > 0 && $urandom_range(0, 3) != 0)
                begin
                    j   = $urandom_range(0, sb.entry_cnt - 1);
                    uid = sb.slots[j].user_id;
                    tag = sb.slots[j].tag;
                end
            end
            else if (r < 90)
                cmd = CMD_SWEEP;
            else
            begin
                cmd  = cmd_t'($urandom_range(0, 3));
                uid  = $urandom;
                tag  = 16'($urandom);
                when = $urandom;
            end
            drive_request(cmd, uid, tag, when);
        end
    endtask

    // Empty the table, fill it, hit full and duplicate, then expire everything
    task automatic fill_and_drain();
        while (sb.entry_cnt > 0)
            drive_request(CMD_UNREGISTER, sb.slots[0].user_id, sb.slots[0].tag, now_s);
        for (int i = 0; i < TABLE_DEPTH; i++)
            drive_request(CMD_REGISTER, $urandom, 16'(i * 2047), now_s);
        drive_request(CMD_REGISTER, sb.slots[7].user_id, sb.slots[7].tag, now_s);
        drive_request(CMD_REGISTER, $urandom, 16'hFFFF, now_s);
        drive_request(CMD_SWEEP, 32'd0, 16'd0, now_s + 32'd65535);
        drive_request(CMD_SWEEP, 32'd0, 16'd0, now_s + 32'd65536);
        now_s = now_s + 32'd65536;
    endtask

    // Result side: random stalls, one long hold-off
    initial
    begin : result_sink
        int      stall;
        bit      held;
        result_t got;
        held = 1'b0;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = idle_cycles();
            if (!held && sb.accepted >= 190)
            begin
                held  = 1'b1;
                stall = 400;
            end
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_ch.valid !== 1'b1);
            got.status          = status_t'(rsp_ch.status);
            got.start_timer     = rsp_ch.start_timer;
            got.expired_valid   = rsp_ch.expired_valid;
            got.expired_user_id = rsp_ch.expired_user_id;
            got.expired_tag     = rsp_ch.expired_tag;
            got.table_not_empty = rsp_ch.table_not_empty;
            got.last            = rsp_ch.last;
            sb.check_result(got);
        end
    end

    // Request side and phase sequencing
    initial
    begin : stimulus
        int waited;
        no_idle             = 1'b0;
        rst_n               = 1'b0;
        cfg_write_en        = 1'b0;
        cfg_write_data      = '0;
        req_ch.valid        = 1'b0;
        req_ch.command      = '0;
        req_ch.user_id      = '0;
        req_ch.session_tag  = '0;
        req_ch.current_time = '0;
        uid_pool[0] = 32'h8000_0000;
        uid_pool[1] = 32'h7FFF_FFFF;
        uid_pool[2] = 32'd0;
        uid_pool[3] = 32'hFFFF_FFFF;
        uid_pool[4] = 32'd1;
        for (int i = 5; i < 8; i++)
            uid_pool[i] = $urandom;
        tag_pool[0] = 16'd0;
        tag_pool[1] = 16'hFFFF;
        tag_pool[2] = 16'd1;
        tag_pool[3] = 16'($urandom);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default timeout from reset
        directed_checks();

        wait_idle();
        set_timeout(16'd0);
        now_s = 32'h0000_2000;
        random_phase(60, 3);

        wait_idle();
        set_timeout(16'hFFFF);
        fill_and_drain();

        // back-to-back stretch, no idling on either side
        wait_idle();
        no_idle = 1'b1;
        set_timeout(16'd5);
        random_phase(50, 12);

        wait_idle();
        no_idle = 1'b0;
        set_timeout(16'd100);
        random_phase(90, 220);

        req_ch.valid <= 1'b0;
        waited = 0;
        while (sb.expected_results.size() != 0 && waited < 50000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (100) @(posedge clk);
        if (sb.expected_results.size() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d expected results never arrived", $time,
                     sb.expected_results.size());
        end
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/stt_pkg.sv
sv/stt_in_if.sv
sv/stt_out_if.sv
sv/session_timeout_table.sv
bench/tb_top.sv
